// ===== design/spa_pkg.sv =====
// Package for the slot pool allocator: field widths, command and status codes,
// and the decode record passed from the mark unit to the top level.
// No dependencies.
package spa_pkg;

    // Pool geometry.
    localparam int SLOTS   = 32;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);

    // Field widths of the stream beats.
    localparam int CMD_W   = 3;
    localparam int SLOT_W  = 5;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 6;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 48;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LEASE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FREE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_INACTIVE = 2'd2;

    // Result of decoding one command against the active marks.
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot_out;
        logic [COUNT_W-1:0] count;
        logic               ram_we;
        logic               ram_re;
        logic [IDX_W-1:0]   ram_addr;
    } t_dec;

endpackage

// ===== design/slot_pool_allocator.sv =====
// Slot pool allocator top level: stream ports, value RAM, mark unit and the
// result pipeline. Depends on spa_pkg, spa_ram and spa_marks.
// A result is registered in stage one and then in the output register.
// Throughput: one command per cycle unless results stall; the mark update and
// value RAM access end in the accept cycle, so no command waits on the last.
// Reset (synchronous, active low) frees every slot and clears the count at
// once; slot values are undefined until written and need no clearing pass.
module slot_pool_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Command stream: cmd[2:0], slot[7:3], value_in[39:8].
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [spa_pkg::IN_W-1:0]    s_axis_tdata,
    // Result stream: status[1:0], slot_out[6:2], value_out[38:7],
    // active_count[44:39], zeros above.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [spa_pkg::OUT_W-1:0]   m_axis_tdata
);
    import spa_pkg::*;

    logic                in_beat;
    logic                s1_move;
    logic [CMD_W-1:0]    in_cmd;
    logic [SLOT_W-1:0]   in_slot;
    logic [VAL_W-1:0]    in_value;
    t_dec                dec;
    logic [VAL_W-1:0]    ram_rdata;
    logic [VAL_W-1:0]    s1_value;

    logic                r_s1_valid;
    logic [STAT_W-1:0]   r_s1_status;
    logic [SLOT_W-1:0]   r_s1_slot;
    logic [COUNT_W-1:0]  r_s1_count;
    logic                r_s1_rd_ok;
    logic                r_o_valid;
    logic [OUT_W-1:0]    r_o_data;

    // Unpack the command beat.
    assign in_cmd   = s_axis_tdata[2:0];
    assign in_slot  = s_axis_tdata[7:3];
    assign in_value = s_axis_tdata[39:8];

    // Stage one drains into the output register when that is free or taken.
    assign s1_move       = r_s1_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_move;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    spa_marks u_marks (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_beat),
        .i_cmd   (in_cmd),
        .i_slot  (in_slot),
        .o_dec   (dec)
    );

    spa_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SLOTS)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (in_beat && dec.ram_we),
        .i_re    (in_beat && dec.ram_re),
        .i_addr  (dec.ram_addr),
        .i_wdata (in_value),
        .o_rdata (ram_rdata)
    );

    // Stage one: decoded result waits here while the RAM read completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_beat) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_status <= dec.status;
            r_s1_slot   <= dec.slot_out;
            r_s1_count  <= dec.count;
            r_s1_rd_ok  <= dec.ram_re;
        end
    end

    // Only a successful read returns stored data.
    assign s1_value = r_s1_rd_ok ? ram_rdata : '0;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_move) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_data <= {3'b000, r_s1_count, s1_value, r_s1_slot, r_s1_status};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

    // A pool-full result reports slot zero and a full count.
    a_full_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == ST_FULL)) |->
        ((m_axis_tdata[6:2] == '0) && (m_axis_tdata[44:39] == COUNT_W'(SLOTS))))
        else $error("pool-full result with wrong slot or count");

    // A rejected command never returns stored data.
    a_inactive_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == ST_INACTIVE)) |->
        (m_axis_tdata[38:7] == '0))
        else $error("inactive-slot result carries a value");

    // The count never exceeds the pool size.
    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[44:39]) <= SLOTS))
        else $error("active count above pool size");

    // A held stage-one result keeps its contents until it moves on.
    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=>
        (r_s1_valid && $stable(r_s1_status) && $stable(r_s1_count) && $stable(s1_value)))
        else $error("stage-one result lost or changed while held");

endmodule

// ===== design/spa_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing; width and depth are set by parameters.
module spa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable; the read data register holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/spa_marks.sv =====
// Active-mark unit: holds one mark per slot and the active count, finds the
// lowest free slot and decodes each command. Depends on spa_pkg.
module spa_marks (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [spa_pkg::CMD_W-1:0]  i_cmd,
    input  logic [spa_pkg::SLOT_W-1:0] i_slot,
    output spa_pkg::t_dec         o_dec
);
    import spa_pkg::*;

    logic [SLOTS-1:0] r_marks;
    logic [SLOTS-1:0] n_marks;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] slot_idx;
    logic             slot_hit;

    // Priority encoder: lowest slot whose mark is clear.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_marks[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // A slot is usable when it lies inside the pool and is marked active.
    assign slot_idx = IDX_W'(i_slot);
    assign slot_hit = (32'(i_slot) < SLOTS) && r_marks[slot_idx];

    // Command decode and next state of the marks and the count.
    always_comb begin
        n_marks        = r_marks;
        n_count        = r_count;
        o_dec.status   = ST_OK;
        o_dec.slot_out = i_slot;
        o_dec.ram_we   = 1'b0;
        o_dec.ram_re   = 1'b0;
        o_dec.ram_addr = slot_idx;
        unique case (i_cmd) inside
            CMD_ADD, CMD_LEASE: begin
                if (free_found) begin
                    n_marks[free_idx] = 1'b1;
                    n_count           = r_count + 1'b1;
                    o_dec.slot_out    = SLOT_W'(free_idx);
                    o_dec.ram_we      = (i_cmd == CMD_ADD);
                    o_dec.ram_addr    = free_idx;
                end else begin
                    o_dec.status   = ST_FULL;
                    o_dec.slot_out = '0;
                end
            end
            CMD_WRITE: begin
                if (slot_hit) begin
                    o_dec.ram_we = 1'b1;
                end else begin
                    o_dec.status = ST_INACTIVE;
                end
            end
            CMD_FREE: begin
                if (slot_hit) begin
                    n_marks[slot_idx] = 1'b0;
                    n_count           = r_count - 1'b1;
                end else begin
                    o_dec.status = ST_INACTIVE;
                end
            end
            CMD_CLEAR: begin
                n_marks = '0;
                n_count = '0;
            end
            CMD_READ: begin
                if (slot_hit) begin
                    o_dec.ram_re = 1'b1;
                end else begin
                    o_dec.status = ST_INACTIVE;
                end
            end
            default: begin
            end
        endcase
        o_dec.count = COUNT_W'(n_count);
    end

    // Marks and count change only on an accepted command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
            r_count <= '0;
        end else if (i_en) begin
            r_marks <= n_marks;
            r_count <= n_count;
        end
    end

endmodule
